[rtl/fpa_pkg.sv]
// Package: opcodes, widths and the divider cell's control payload.
package fpa_pkg;
    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    localparam int DIVD_W    = DATA_W + FRAC_BITS;
    // the magnitude quotient needs the full dividend width
    localparam int QUOT_W    = DIVD_W;
    localparam int STAGES    = QUOT_W;

    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_MUL     = 4'd2,
        OP_DIV     = 4'd3,
        OP_GT      = 4'd4,
        OP_LT      = 4'd5,
        OP_GE      = 4'd6,
        OP_LE      = 4'd7,
        OP_EQ      = 4'd8,
        OP_NE      = 4'd9,
        OP_MIN     = 4'd10,
        OP_MAX     = 4'd11,
        OP_INC     = 4'd12,
        OP_DEC     = 4'd13,
        OP_TOINT   = 4'd14,
        OP_FROMINT = 4'd15
    } op_t;

    // what travels alongside the divider data through each cell
    typedef struct packed {
        logic              vld;
        logic              is_div;
        logic              neg_q;
        logic              dz;
        logic              cmp;
        logic [DATA_W-1:0] val;
    } ctl_t;
endpackage

[rtl/fpa_cell.sv]
// One divider cell: a single restoring-division step plus the sideband registers.
module fpa_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  fpa_pkg::ctl_t                ctl_in,
    input  logic [fpa_pkg::DIVD_W-1:0]   rem_in,
    input  logic [fpa_pkg::DIVD_W-1:0]   dvd_in,
    input  logic [fpa_pkg::DATA_W-1:0]   dvs_in,
    output fpa_pkg::ctl_t                ctl_out,
    output logic [fpa_pkg::DIVD_W-1:0]   rem_out,
    output logic [fpa_pkg::DIVD_W-1:0]   dvd_out,
    output logic [fpa_pkg::DATA_W-1:0]   dvs_out
);
    import fpa_pkg::*;

    logic [DIVD_W-1:0] shifted;
    logic [DIVD_W:0]   diff;
    logic              fits;
    logic [DIVD_W-1:0] rem_next;
    logic [DIVD_W-1:0] dvd_next;
    logic              vld_reg;
    ctl_t              ctl_reg;
    logic [DIVD_W-1:0] rem_reg;
    logic [DIVD_W-1:0] dvd_reg;
    logic [DATA_W-1:0] dvs_reg;

    // dividend shifts out from the top; quotient bits fill in from the bottom
    always_comb
    begin
        shifted  = {rem_in[DIVD_W-2:0], dvd_in[DIVD_W-1]};
        diff     = {1'b0, shifted} - {{(DIVD_W-DATA_W+1){1'b0}}, dvs_in};
        fits     = ~diff[DIVD_W];
        rem_next = fits ? diff[DIVD_W-1:0] : shifted;
        dvd_next = {dvd_in[DIVD_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= ctl_in.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg <= ctl_in;
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
            dvs_reg <= dvs_in;
        end
    end

    always_comb
    begin
        ctl_out     = ctl_reg;
        ctl_out.vld = vld_reg;
    end

    assign rem_out = rem_reg;
    assign dvd_out = dvd_reg;
    assign dvs_out = dvs_reg;
endmodule

[rtl/fpa_front.sv]
// Front stage: decodes the op, computes the non-divide ops and the product, preps the divide.
module fpa_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_vld,
    input  logic [3:0]                   op,
    input  logic signed [fpa_pkg::DATA_W-1:0] operand_a,
    input  logic signed [fpa_pkg::DATA_W-1:0] operand_b,
    output fpa_pkg::ctl_t                ctl_out,
    output logic [fpa_pkg::DIVD_W-1:0]   dvd_out,
    output logic [fpa_pkg::DATA_W-1:0]   dvs_out
);
    import fpa_pkg::*;

    logic                       vld_reg;
    ctl_t                       ctl_reg;
    logic [DIVD_W-1:0]          dvd_reg;
    logic [DATA_W-1:0]          dvs_reg;
    logic                       mul_reg;
    logic signed [2*DATA_W-1:0] prod_reg;
    ctl_t                       ctl_next;
    logic [DATA_W-1:0]          mag_a;
    logic [DATA_W-1:0]          mag_b;
    logic                       lt;
    logic                       gt;
    logic signed [2*DATA_W-1:0] prod_next;

    always_comb
    begin
        lt        = operand_a < operand_b;
        gt        = operand_a > operand_b;
        mag_a     = operand_a[DATA_W-1] ? DATA_W'(-operand_a) : DATA_W'(operand_a);
        mag_b     = operand_b[DATA_W-1] ? DATA_W'(-operand_b) : DATA_W'(operand_b);
        prod_next = operand_a * operand_b;
        ctl_next  = '0;
        ctl_next.vld = in_vld;
        case (op_t'(op))
            OP_ADD:     ctl_next.val = operand_a + operand_b;
            OP_SUB:     ctl_next.val = operand_a - operand_b;
            OP_DIV:
            begin
                ctl_next.is_div = (operand_b != '0);
                ctl_next.dz     = (operand_b == '0);
                ctl_next.neg_q  = operand_a[DATA_W-1] ^ operand_b[DATA_W-1];
            end
            OP_GT:      ctl_next.cmp = gt;
            OP_LT:      ctl_next.cmp = lt;
            OP_GE:      ctl_next.cmp = ~lt;
            OP_LE:      ctl_next.cmp = ~gt;
            OP_EQ:      ctl_next.cmp = (operand_a == operand_b);
            OP_NE:      ctl_next.cmp = (operand_a != operand_b);
            OP_MIN:     ctl_next.val = lt ? operand_a : operand_b;
            OP_MAX:     ctl_next.val = gt ? operand_a : operand_b;
            OP_INC:     ctl_next.val = operand_a + DATA_W'(1);
            OP_DEC:     ctl_next.val = operand_a - DATA_W'(1);
            OP_TOINT:   ctl_next.val = DATA_W'(operand_a >>> FRAC_BITS);
            OP_FROMINT: ctl_next.val = DATA_W'(operand_a << FRAC_BITS);
            default:    ctl_next.val = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg  <= ctl_next;
            mul_reg  <= (op_t'(op) == OP_MUL);
            prod_reg <= prod_next;
            dvd_reg  <= {mag_a, {FRAC_BITS{1'b0}}};
            dvs_reg  <= mag_b;
        end
    end

    // the product is registered in prod_reg; shift it in after the register
    always_comb
    begin
        ctl_out     = ctl_reg;
        ctl_out.vld = vld_reg;
        if (mul_reg)
        begin
            ctl_out.val = DATA_W'(prod_reg >>> FRAC_BITS);
        end
    end

    assign dvd_out = dvd_reg;
    assign dvs_out = dvs_reg;
endmodule

[rtl/fixed_point_alu.sv]
// Top level of the fixed-point ALU: front stage, divider cell chain, output stage.
//
// Fixed-point ALU on 32-bit signed raw values with FRAC_BITS fraction bits.
// Input channel: in_valid / in_stall with op, operand_a, operand_b.
// Output channel: out_valid / out_stall with value_out, compare_true, div_by_zero.
// Every transaction yields exactly one result, in order.
// Every op, divide or not, passes through the same registers: one front
// stage holding the decode and the 32x32 product, one cell per quotient bit of
// the restoring divider chain, and one output register.
// Throughput: one transaction per cycle while the output is not stalled; the whole chain advances together.
// When the receiver stalls with a result waiting, the whole chain freezes,
// empty slots included, and in_stall rises in that same cycle; it drops
// again in the cycle the receiver takes the waiting result.
// Reset clears every valid bit; the pipeline comes up empty.
module fixed_point_alu (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [3:0]                        op,
    input  logic signed [fpa_pkg::DATA_W-1:0] operand_a,
    input  logic signed [fpa_pkg::DATA_W-1:0] operand_b,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [fpa_pkg::DATA_W-1:0] value_out,
    output logic                              compare_true,
    output logic                              div_by_zero
);
    import fpa_pkg::*;

    ctl_t              ctl_w [0:STAGES];
    logic [DIVD_W-1:0] rem_w [0:STAGES];
    logic [DIVD_W-1:0] dvd_w [0:STAGES];
    logic [DATA_W-1:0] dvs_w [0:STAGES];
    logic              adv;
    logic              out_vld_reg;
    logic [DATA_W-1:0] val_reg;
    logic              cmp_reg;
    logic              dz_reg;
    logic [DATA_W-1:0] val_next;
    ctl_t              tail;

    // advance everything unless a held result blocks the output register
    assign adv      = ~(out_vld_reg & out_stall);
    assign in_stall = ~adv;

    fpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_vld    (in_valid),
        .op        (op),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .ctl_out   (ctl_w[0]),
        .dvd_out   (dvd_w[0]),
        .dvs_out   (dvs_w[0])
    );
    assign rem_w[0] = '0;

    for (genvar i = 0; i < STAGES; i++)
    begin : g_cell
        fpa_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .ctl_in  (ctl_w[i]),
            .rem_in  (rem_w[i]),
            .dvd_in  (dvd_w[i]),
            .dvs_in  (dvs_w[i]),
            .ctl_out (ctl_w[i+1]),
            .rem_out (rem_w[i+1]),
            .dvd_out (dvd_w[i+1]),
            .dvs_out (dvs_w[i+1])
        );
    end

    assign tail = ctl_w[STAGES];

    always_comb
    begin
        val_next = tail.val;
        if (tail.is_div)
        begin
            val_next = tail.neg_q ? DATA_W'(-dvd_w[STAGES]) : DATA_W'(dvd_w[STAGES]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= tail.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            val_reg <= val_next;
            cmp_reg <= tail.cmp;
            dz_reg  <= tail.dz;
        end
    end

    assign out_valid    = out_vld_reg;
    assign value_out    = val_reg;
    assign compare_true = cmp_reg;
    assign div_by_zero  = dz_reg;
endmodule

[bench/fixed_point_alu_tb.sv]
// Testbench for the fixed-point ALU: directed and random operations checked against a predictor.
`timescale 1ns / 1ps

module fixed_point_alu_tb;
    import fpa_pkg::*;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     cmp;
        logic                     dz;
    } alu_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [3:0]               op = 4'd0;
    logic signed [DATA_W-1:0] operand_a = '0;
    logic signed [DATA_W-1:0] operand_b = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] value_out;
    logic                     compare_true;
    logic                     div_by_zero;

    alu_result_t pending_results[$];
    int  errors = 0;
    int  hold_off_cycles = 0;
    bit  quiet_sender = 0;
    bit  quiet_receiver = 0;

    fixed_point_alu dut (.*);

    always #4 clk = ~clk;

    initial
    begin
        #50ms;
        $display("fixed_point_alu: mismatch");
        $finish;
    end

    function automatic alu_result_t alu_predict(op_t code, logic signed [DATA_W-1:0] a,
                                                logic signed [DATA_W-1:0] b);
        alu_result_t r;
        logic signed [2*DATA_W-1:0] prod;
        logic [DIVD_W-1:0] mag_a;
        logic [DIVD_W-1:0] mag_q;
        logic [DATA_W-1:0] mag_b;
        r.value = '0;
        r.cmp = 1'b0;
        r.dz = 1'b0;
        case (code)
            OP_ADD: r.value = a + b;
            OP_SUB: r.value = a - b;
            OP_MUL:
            begin
                prod = 64'(a) * 64'(b);
                r.value = DATA_W'(prod >>> FRAC_BITS);
            end
            OP_DIV:
            begin
                if (b == 0)
                    r.dz = 1'b1;
                else
                begin
                    mag_a = DIVD_W'(a[DATA_W-1] ? -33'(a) : 33'(a)) << FRAC_BITS;
                    mag_b = b[DATA_W-1] ? -b : b;
                    mag_q = mag_a / DIVD_W'(mag_b);
                    r.value = (a[DATA_W-1] != b[DATA_W-1]) ? -DATA_W'(mag_q)
                                                            : DATA_W'(mag_q);
                end
            end
            OP_GT: r.cmp = a > b;
            OP_LT: r.cmp = a < b;
            OP_GE: r.cmp = a >= b;
            OP_LE: r.cmp = a <= b;
            OP_EQ: r.cmp = a == b;
            OP_NE: r.cmp = a != b;
            OP_MIN: r.value = (a < b) ? a : b;
            OP_MAX: r.value = (a > b) ? a : b;
            OP_INC: r.value = a + 1;
            OP_DEC: r.value = a - 1;
            OP_TOINT: r.value = a >>> FRAC_BITS;
            default: r.value = a << FRAC_BITS;
        endcase
        return r;
    endfunction

    // one transaction on the input side, then a random gap
    task automatic send_op(op_t code, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
        int gap;
        op <= code;
        operand_a <= a;
        operand_b <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(alu_predict(code, a, b));
        gap = quiet_sender ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [DATA_W-1:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF - $urandom_range(0, 2);
            1: return 32'h8000_0000 + $urandom_range(0, 2);
            2: return $urandom_range(0, 4) - 2;
            3: return DATA_W'($signed($urandom_range(0, 8191)) - 4096);
            4: return DATA_W'($signed($urandom_range(0, 2097151)) - 1048576);
            default: return $urandom;
        endcase
    endfunction

    // receiver: random stall per result, and an optional long hold-off
    initial
    begin : receiver
        int wait_cycles;
        alu_result_t exp_r;
        wait_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%t unexpected result value=%h", $time, value_out);
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (value_out !== exp_r.value || compare_true !== exp_r.cmp
                        || div_by_zero !== exp_r.dz)
                    begin
                        errors++;
                        $display("%t expected %h/%b/%b actual %h/%b/%b", $time,
                                 exp_r.value, exp_r.cmp, exp_r.dz,
                                 value_out, compare_true, div_by_zero);
                    end
                end
                wait_cycles = quiet_receiver ? 0 : $urandom_range(0, 16);
                if ($urandom_range(0, 3) == 0)
                    wait_cycles = 0;
            end
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                out_stall <= 1'b1;
            end
            else if (wait_cycles > 0)
            begin
                wait_cycles--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic test_directed();
        logic [DATA_W-1:0] edges[6];
        edges = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0100};
        for (int c = 0; c < 16; c++)
            send_op(op_t'(c), edges[c % 6], edges[(c + 2) % 6]);
        send_op(OP_DIV, 32'h0000_1234, 32'h0);
        send_op(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        send_op(OP_DIV, 32'h7FFF_FFFF, 32'h1);
        send_op(OP_MUL, 32'h8000_0000, 32'h8000_0000);
        send_op(OP_MUL, 32'hFFFF_FFFF, 32'h1);
        send_op(OP_TOINT, 32'hFFFF_FF01, 32'h0);
        send_op(OP_FROMINT, 32'h00FF_FFFF, 32'h0);
        send_op(OP_EQ, 32'h8000_0000, 32'h8000_0000);
    endtask

    task automatic test_random(int count);
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        for (int i = 0; i < count; i++)
        begin
            quiet_sender = (i / 100) % 3 == 2;
            quiet_receiver = (i / 100) % 4 == 3;
            a = rand_operand();
            b = ($urandom_range(0, 9) == 0) ? a : rand_operand();
            if ($urandom_range(0, 15) == 0)
                b = '0;
            send_op(op_t'($urandom_range(0, 15)), a, b);
        end
        quiet_sender = 0;
        quiet_receiver = 0;
    endtask

    // hold the output long enough that the pipeline fills and backs up
    task automatic test_backpressure();
        quiet_sender = 1;
        hold_off_cycles = 200;
        for (int i = 0; i < 80; i++)
            send_op(op_t'($urandom_range(0, 15)), rand_operand(), rand_operand());
        quiet_sender = 0;
    endtask

    initial
    begin : main
        int guard;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(600);
        test_backpressure();
        test_random(500);
        in_valid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (STAGES + 10) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("fixed_point_alu: match");
        else
            $display("fixed_point_alu: mismatch");
        $finish;
    end
endmodule

[fixed_point_alu.f]
rtl/fpa_pkg.sv
rtl/fpa_cell.sv
rtl/fpa_front.sv
rtl/fixed_point_alu.sv
bench/fixed_point_alu_tb.sv
